[sv/sha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Payload types, command/status structs, constants and round functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // datapath commands from the controller
  typedef struct packed {
    logic       absorb;      // write byte into block, advance byte counter
    logic [7:0] abs_byte;
    logic       count_len;   // add 8 to bit count
    logic       start;       // load working vars from hash, clear round
    logic       round;       // one compression round
    logic       finish;      // hash += working vars
    logic       reset_msg;   // hash to IV, count and position to zero
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] pos;         // byte_in_block
    logic       last_round;
    logic [7:0] len_byte;    // length byte selected by pos
  } dp_sts_t;

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[sv/sha_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer as a 16-word shift window, working vars, hash and length count.
// ----------------------------------------------------------------------------
module sha_datapath #(
  parameter int LENGTH_COUNTER_BITS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha_pkg::dp_cmd_t cmd_i,
  output sha_pkg::dp_sts_t sts_o,
  output logic [31:0]      hash_o [8]
);

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [LENGTH_COUNTER_BITS-1:0] cnt_q;
  logic [5:0] pos_q;
  logic [5:0] rnd_q;
  logic [63:0] len_ext;
  logic [31:0] s0, s1, wn, t1, t2;
  logic [3:0] widx;
  logic [4:0] sh;

  assign len_ext = 64'(cnt_q);
  assign widx = pos_q[5:2];
  assign sh = 5'((3 - int'(pos_q[1:0])) * 8);

  always_comb begin
    s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    t1 = v_q[7] + (sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^
         sha_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) +
         sha_pkg::K[rnd_q] + w_q[0];
    t2 = (sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^
         sha_pkg::rotr(v_q[0], 22)) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^
         (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= sha_pkg::IV;
      cnt_q <= '0;
      pos_q <= '0;
      rnd_q <= '0;
    end else begin
      if (cmd_i.count_len) cnt_q <= cnt_q + LENGTH_COUNTER_BITS'(8);
      if (cmd_i.absorb) pos_q <= pos_q + 6'd1;
      if (cmd_i.start) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.finish) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.reset_msg) begin
        h_q   <= sha_pkg::IV;
        cnt_q <= '0;
        pos_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb) begin
      if (pos_q[1:0] == 2'd0) w_q[widx] <= {24'd0, cmd_i.abs_byte} << sh;
      else w_q[widx] <= w_q[widx] | ({24'd0, cmd_i.abs_byte} << sh);
    end
    if (cmd_i.start) v_q <= h_q;
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign sts_o.pos        = pos_q;
  assign sts_o.last_round = (rnd_q == 6'd63);
  assign sts_o.len_byte   = len_ext[8*(7-int'(pos_q[2:0])) +: 8];
  assign hash_o           = h_q;

endmodule

[sv/sha_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorb, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_item_t out_data_o,
  output sha_pkg::dp_cmd_t   cmd_o,
  input  sha_pkg::dp_sts_t   sts_i,
  input  logic [31:0]        hash_i [8]
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StLen  = 3'd2;
  localparam logic [2:0] StRnd  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] st_q, st_d;
  logic       ending_q, ending_d;
  logic       padded_q, padded_d;
  // a compression after the length bytes leads to output
  logic       out_next_q, out_next_d;
  logic [2:0] idx_q, idx_d;
  logic [5:0] nxt;
  logic       acc;

  assign in_ready_o = (st_q == StIdle);
  assign acc = in_valid_i && in_ready_o;
  assign nxt = sts_i.pos + 6'd1;
  assign out_valid_o = (st_q == StOut);
  assign out_data_o.digest_word = hash_i[idx_q];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == 3'd7);

  always_comb begin
    st_d = st_q;
    ending_d = ending_q;
    padded_d = padded_q;
    out_next_d = out_next_q;
    idx_d = idx_q;
    cmd_o = '0;
    unique case (st_q)
      StIdle: begin
        if (acc) begin
          ending_d = in_data_i.end_of_message;
          padded_d = 1'b0;
          if (in_data_i.byte_present) begin
            cmd_o.absorb = 1'b1;
            cmd_o.abs_byte = in_data_i.data_byte;
            cmd_o.count_len = 1'b1;
            if (nxt == 6'd0) begin
              cmd_o.start = 1'b1;
              st_d = StRnd;
            end else if (in_data_i.end_of_message) st_d = StPad;
          end else if (in_data_i.end_of_message) st_d = StPad;
        end
      end
      StPad: begin
        cmd_o.absorb = 1'b1;
        cmd_o.abs_byte = padded_q ? 8'd0 : sha_pkg::PadByte;
        padded_d = 1'b1;
        if (nxt == 6'd0) begin
          cmd_o.start = 1'b1;
          st_d = StRnd;
        end else if (nxt == sha_pkg::LenPos) st_d = StLen;
      end
      StLen: begin
        cmd_o.absorb = 1'b1;
        cmd_o.abs_byte = sts_i.len_byte;
        if (nxt == 6'd0) begin
          cmd_o.start = 1'b1;
          padded_d = 1'b0;
          ending_d = 1'b0;
          out_next_d = 1'b1;
          st_d = StRnd;
          idx_d = '0;
        end
      end
      StRnd: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) st_d = StFin;
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        if (ending_q) st_d = StPad;
        else if (out_next_q) begin
          out_next_d = 1'b0;
          st_d = StOut;
        end else st_d = StIdle;
      end
      StOut: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.reset_msg = 1'b1;
            st_d = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ending_q <= 1'b0;
      padded_q <= 1'b0;
      idx_q <= '0;
      out_next_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ending_q <= ending_d;
      padded_q <= padded_d;
      idx_q <= idx_d;
      out_next_q <= out_next_d;
    end
  end

  a_out_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && idx_q == 3'd7 |=> st_q == StIdle)
    else $error("digest did not end after word 7");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StRnd |-> !in_ready_o)
    else $error("input taken during compression");
  a_round_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> st_q == StRnd)
    else $error("start without rounds");

endmodule

[sv/sha256_message_digest_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest unit
// Byte-stream SHA-256: one byte per input transfer, eight digest words out.
// ----------------------------------------------------------------------------
// Input transfer: data_byte with byte_present, end_of_message closes message.
// A plain byte is written into the block; the 64th byte of a block starts the
// rounds and the finish step of the single shared round unit.
// End of message: padding is absorbed one byte per cycle up to byte 64, then
// the block compresses; one or two blocks follow, after which
// eight output transfers carry H0..H7, last_word on the eighth.
// Input is not taken while padding, compressing or presenting the digest.
// A stalled receiver holds the current word; nothing is lost.
// Reset loads the initial hash words and clears the length and position.
// ----------------------------------------------------------------------------
module sha256_message_digest_unit #(
  parameter int LENGTH_COUNTER_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_item_t out_data_o
);

  sha_pkg::dp_cmd_t cmd;
  sha_pkg::dp_sts_t sts;
  logic [31:0] hash [8];

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cmd_o(cmd), .sts_i(sts), .hash_i(hash)
  );

  sha_datapath #(.LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .hash_o(hash)
  );

endmodule
